// ===== rtl/zfc_pkg.sv =====
// zfc_pkg: shared types, constants and command/status structs for the
// zero-forcing closure core; no dependencies
package zfc_pkg;

	localparam int unsigned MAX_ORDER  = 31;
	localparam int unsigned MIN_ORDER  = 9;
	localparam int unsigned STEP_INNER = 4;
	localparam int unsigned ORD_W      = 5;
	localparam int unsigned RING_W     = MAX_ORDER;
	localparam int unsigned SET_W      = 2 * MAX_ORDER;
	localparam int unsigned CNT_W      = 40;

	typedef logic [ORD_W-1:0]  order_t;
	typedef logic [RING_W-1:0] ring_t;
	typedef logic [SET_W-1:0]  set_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic settled;
	} dp_status_t;

endpackage

// ===== rtl/zfc_ctrl.sv =====
// zfc_ctrl: sequencer for the zero-forcing closure core
// uses zfc_pkg; drives dp_cmd_t commands into zfc_datapath
module zfc_ctrl import zfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	output logic       result_valid,
	input  logic       result_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_ROUND
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   out_free;

	assign out_free     = !result_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && item_valid;
		cmd.step   = (state_q == ST_ROUND) && !status.settled;
		cmd.finish = (state_q == ST_ROUND) && status.settled && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (status.settled && out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!result_valid_q || !result_stall))
		else $error("result overwritten while stalled");

	// a finished item always shows up at the output next cycle
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result_valid_q)
		else $error("finished item not presented");

	// no new item enters while one is in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> !cmd.load)
		else $error("item loaded during forcing rounds");

endmodule

// ===== rtl/zfc_datapath.sv =====
// zfc_datapath: split ring registers, one parallel forcing round per cycle,
// result register, saturating counters and witness; uses zfc_pkg
module zfc_datapath import zfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  order_t     cfg_order,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  set_t       initial_set,
	output set_t       closed_set,
	output logic       all_forced,
	output cnt_t       tested_total,
	output cnt_t       forcing_total,
	output set_t       first_forcing_set
);

	// result[i] = v[(i + k) mod n], bits at or above n are don't care
	function automatic ring_t ring_pick(ring_t v, order_t k, order_t n);
		logic [SET_W-1:0] ext;
		ext = {{RING_W{1'b0}}, v} | ({{RING_W{1'b0}}, v} << n);
		ext = ext >> k;
		return ext[RING_W-1:0];
	endfunction

	// exactly one of three bits set, per lane
	function automatic ring_t one_of3(ring_t a, ring_t b, ring_t c);
		return (a ^ b ^ c) & ~(a & b & c);
	endfunction

	order_t order_q;
	ring_t  outer_q;
	ring_t  inner_q;
	set_t   init_q;
	set_t   closed_q;
	logic   all_q;
	cnt_t   tested_q;
	cnt_t   forcing_q;
	set_t   witness_q;

	order_t      n_m1;
	order_t      n_m4;
	ring_t       nmask;
	logic [63:0] full_wide;
	set_t        full;
	set_t        init_masked;
	set_t        init_hi;
	ring_t       wo, wi;
	ring_t       fo, fi;
	ring_t       add_o, add_i;
	logic        all_now;
	set_t        closed_now;

	assign n_m1      = order_q - order_t'(1);
	assign n_m4      = order_q - order_t'(STEP_INNER);
	assign nmask     = ring_t'((32'd1 << order_q) - 32'd1);
	assign full_wide = (64'd1 << {order_q, 1'b0}) - 64'd1;
	assign full      = full_wide[SET_W-1:0];

	assign init_masked = initial_set & full;
	assign init_hi     = init_masked >> order_q;

	// white vertices, split into outer and inner rings
	assign wo = ~outer_q & nmask;
	assign wi = ~inner_q & nmask;

	// black vertices with exactly one white neighbour
	assign fo = outer_q & one_of3(ring_pick(wo, order_t'(1), order_q),
		ring_pick(wo, n_m1, order_q), wi);
	assign fi = inner_q & one_of3(wo,
		ring_pick(wi, order_t'(STEP_INNER), order_q),
		ring_pick(wi, n_m4, order_q));

	// white vertices that some forcing neighbour points at
	assign add_o = wo & (ring_pick(fo, order_t'(1), order_q) |
		ring_pick(fo, n_m1, order_q) | fi);
	assign add_i = wi & (fo | ring_pick(fi, order_t'(STEP_INNER), order_q) |
		ring_pick(fi, n_m4, order_q));

	assign status.settled = (add_o == '0) && (add_i == '0);

	assign all_now    = (outer_q == nmask) && (inner_q == nmask);
	assign closed_now = {{RING_W{1'b0}}, outer_q} |
		({{RING_W{1'b0}}, inner_q} << order_q);

	// effective ring order, clamped at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= order_t'(MIN_ORDER);
		end else if (cfg_we) begin
			if (cfg_order < order_t'(MIN_ORDER)) begin
				order_q <= order_t'(MIN_ORDER);
			end else begin
				order_q <= cfg_order;
			end
		end
	end

	// working set and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			outer_q <= init_masked[RING_W-1:0] & nmask;
			inner_q <= init_hi[RING_W-1:0] & nmask;
			init_q  <= init_masked;
		end else if (cmd.step) begin
			outer_q <= outer_q | add_o;
			inner_q <= inner_q | add_i;
		end
		if (cmd.finish) begin
			closed_q <= closed_now;
			all_q    <= all_now;
		end
	end

	// running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tested_q  <= '0;
			forcing_q <= '0;
			witness_q <= '0;
		end else if (cmd.finish) begin
			if (tested_q != '1) begin
				tested_q <= tested_q + cnt_t'(1);
			end
			if (all_now) begin
				if (forcing_q != '1) begin
					forcing_q <= forcing_q + cnt_t'(1);
				end
				if (witness_q == '0) begin
					witness_q <= init_q;
				end
			end
		end
	end

	assign closed_set        = closed_q;
	assign all_forced        = all_q;
	assign tested_total      = tested_q;
	assign forcing_total     = forcing_q;
	assign first_forcing_set = witness_q;

	// forcing only ever adds black vertices
	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (((outer_q & $past(outer_q)) == $past(outer_q)) &&
			((inner_q & $past(inner_q)) == $past(inner_q))))
		else $error("forcing round cleared a black vertex");

	// forcing sets are a subset of tested sets
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		forcing_q <= tested_q)
		else $error("forcing count exceeds tested count");

	// a recorded witness stays fixed
	a_witness_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(witness_q) != '0) |-> (witness_q == $past(witness_q)))
		else $error("witness changed after being recorded");

endmodule

// ===== rtl/zero_forcing_closure_core.sv =====
// zero_forcing_closure_core: top level of the zero-forcing closure engine
// instantiates zfc_ctrl and zfc_datapath; uses zfc_pkg
//
// Computes the zero-forcing closure of a starting vertex set on the
// generalized Petersen graph GP(n,4): outer ring 0..n-1, inner vertices
// n..2n-1 joined with step 4, spokes from outer i to inner i. One parallel
// forcing round runs per clock on a shared round unit, until a round adds no
// vertex. The result of an item is then registered and the block returns to
// idle, where it takes the next item; it does not take a new item while one
// is still in its rounds. While a result sits unaccepted the block can take
// and work on the next item; it only holds in its final round if the earlier
// result has still not left. tested_total and forcing_total are running
// counts that saturate at 2^40-1; they and first_forcing_set persist across
// items. ring_order is written through the cfg transaction channel, always
// ready; the user must write it only while idle, and the block itself does
// not enforce this; values below 9 act as 9.
module zero_forcing_closure_core import zfc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	// config channel
	input  logic   cfg_valid,
	output logic   cfg_ready,
	input  order_t ring_order,
	// item channel
	input  logic   item_valid,
	output logic   item_stall,
	input  set_t   initial_set,
	// result channel
	output logic   result_valid,
	input  logic   result_stall,
	output set_t   closed_set,
	output logic   all_forced,
	output cnt_t   tested_total,
	output cnt_t   forcing_total,
	output set_t   first_forcing_set
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       cfg_we;

	// register write completes on any valid transaction
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer: accept, iterate rounds, hand result off
	zfc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// round unit, result register and statistics
	zfc_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_order         (ring_order),
		.cmd               (cmd),
		.status            (status),
		.initial_set       (initial_set),
		.closed_set        (closed_set),
		.all_forced        (all_forced),
		.tested_total      (tested_total),
		.forcing_total     (forcing_total),
		.first_forcing_set (first_forcing_set)
	);

endmodule

// ===== sim/testbench.sv =====
// testbench.sv: self-checking bench for zero_forcing_closure_core; a scoreboard
// recomputes every closure, the forcing flag and the running totals
// depends on zfc_pkg and the core rtl

import zfc_pkg::*;

typedef struct {
	set_t closed;
	logic all;
	cnt_t tested;
	cnt_t forcing;
	set_t witness;
} closure_t;

class closure_scoreboard;
	order_t   order_reg;
	cnt_t     tested_cnt;
	cnt_t     forcing_cnt;
	set_t     earliest_witness;
	closure_t pending_q[$];
	int       errors;

	function new();
		order_reg        = order_t'(MIN_ORDER);
		tested_cnt       = '0;
		forcing_cnt      = '0;
		earliest_witness = '0;
		errors           = 0;
	endfunction

	function void set_order(order_t v);
		order_reg = v;
	endfunction

	// register keeps raw bits, the core clamps them into 9..31
	function int order_in_use();
		int n;
		n = int'(order_reg);
		if (n < int'(MIN_ORDER))
			n = MIN_ORDER;
		if (n > int'(MAX_ORDER))
			n = MAX_ORDER;
		return n;
	endfunction

	function int outstanding();
		return pending_q.size();
	endfunction

	static function set_t vertex_mask(int n);
		logic [63:0] m;
		m = (64'd1 << (2 * n)) - 64'd1;
		return m[SET_W-1:0];
	endfunction

	static function set_t adjacent(int v, int n);
		int i;
		if (v < n)
			return (set_t'(1) << ((v + n - 1) % n)) | (set_t'(1) << ((v + 1) % n)) |
				(set_t'(1) << (n + v));
		i = v - n;
		return (set_t'(1) << i) | (set_t'(1) << (n + (i + n - STEP_INNER) % n)) |
			(set_t'(1) << (n + (i + STEP_INNER) % n));
	endfunction

	// parallel rounds: every black vertex with one white neighbour forces it
	static function set_t forced_closure(set_t start, int n);
		set_t black;
		set_t add;
		set_t w;
		black = start;
		for (int r = 0; r <= 2 * n; r++) begin
			add = '0;
			for (int v = 0; v < 2 * n; v++) begin
				if (black[v]) begin
					w = adjacent(v, n) & ~black;
					if (w != '0 && (w & (w - 1'b1)) == '0)
						add |= w;
				end
			end
			if ((black | add) == black)
				break;
			black |= add;
		end
		return black;
	endfunction

	function void note_set(set_t raw);
		closure_t e;
		int       n;
		set_t     full;
		set_t     init;
		n        = order_in_use();
		full     = vertex_mask(n);
		init     = raw & full;
		e.closed = forced_closure(init, n) & full;
		e.all    = (e.closed == full);
		if (tested_cnt != '1)
			tested_cnt++;
		if (e.all) begin
			if (forcing_cnt != '1)
				forcing_cnt++;
			if (earliest_witness == '0)
				earliest_witness = init;
		end
		e.tested  = tested_cnt;
		e.forcing = forcing_cnt;
		e.witness = earliest_witness;
		pending_q.push_back(e);
	endfunction

	function void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
		end
	endfunction

	function void check_closure(set_t c, logic a, cnt_t t, cnt_t f, set_t w);
		closure_t e;
		if (pending_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none actual closed_set %h", $time, c);
			return;
		end
		e = pending_q.pop_front();
		check_field("closed_set", e.closed, c);
		check_field("all_forced", e.all, a);
		check_field("tested_total", e.tested, t);
		check_field("forcing_total", e.forcing, f);
		check_field("first_forcing_set", e.witness, w);
	endfunction
endclass

module testbench;
	localparam int STUCK_LIMIT = 5000;
	localparam int PHASE_ITEMS = 133;

	logic   clk          = 1'b0;
	logic   arst_n       = 1'b0;
	logic   cfg_valid    = 1'b0;
	logic   cfg_ready;
	order_t ring_order   = order_t'(MIN_ORDER);
	logic   item_valid   = 1'b0;
	logic   item_stall;
	set_t   initial_set  = '0;
	logic   result_valid;
	logic   result_stall = 1'b0;
	set_t   closed_set;
	logic   all_forced;
	cnt_t   tested_total;
	cnt_t   forcing_total;
	set_t   first_forcing_set;

	// set during the stretch where neither side idles
	bit steady = 1'b0;
	int stuck_cycles = 0;

	closure_scoreboard sb;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	zero_forcing_closure_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.ring_order        (ring_order),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.initial_set       (initial_set),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.closed_set        (closed_set),
		.all_forced        (all_forced),
		.tested_total      (tested_total),
		.forcing_total     (forcing_total),
		.first_forcing_set (first_forcing_set)
	);

	// result side back-pressure
	always @(negedge clk) begin
		result_stall <= steady ? 1'b0 : ($urandom_range(99) < 36);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_closure(closed_set, all_forced, tested_total, forcing_total,
				first_forcing_set);
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic offer_set(set_t s);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 36) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid  <= 1'b1;
		initial_set <= s;
		do
			@(posedge clk);
		while (item_stall);
		sb.note_set(s);
	endtask

	task automatic wait_all_closed();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	// order is only changed with the core drained
	task automatic write_ring_order(order_t v);
		wait_all_closed();
		cfg_valid  <= 1'b1;
		ring_order <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_order(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic set_t pick_start_set(int n);
		set_t full;
		set_t outer;
		set_t s;
		int   kind;
		full  = sb.vertex_mask(n);
		outer = (set_t'(1) << n) - 1'b1;
		kind  = $urandom_range(99);
		if (kind < 25) begin
			// few seeds, mostly stalls early
			s = '0;
			repeat ($urandom_range(1, 6))
				s[$urandom_range(2 * n - 1)] = 1'b1;
		end else if (kind < 55) begin
			// a whole ring black forces the other ring over the spokes; perturb it
			s = $urandom_range(1) ? outer : (outer << n);
			repeat ($urandom_range(0, 3))
				s ^= set_t'(1) << $urandom_range(2 * n - 1);
		end else if (kind < 80) begin
			s = set_t'({$urandom, $urandom}) | set_t'({$urandom, $urandom});
		end else begin
			s = set_t'({$urandom, $urandom});
		end
		// stray bits above the graph
		if ($urandom_range(3) == 0)
			s |= set_t'({$urandom, $urandom}) & ~full;
		return s;
	endfunction

	initial begin
		set_t   nine_cases [12] = '{
			62'h0, 62'h3FFF_FFFF_FFFF_FFFF, 62'h1FF, 62'h3FE00, 62'h1, 62'h3FFFF,
			62'h3FFFE, 62'h2AAA_AAAA_AAAA_AAAA, 62'h2000_0000_0000_0000,
			62'h3FFF_FFFF_FFFC_0000, 62'h1FE, 62'h201FF
		};
		set_t   top_cases [7] = '{
			62'h0, 62'h3FFF_FFFF_FFFF_FFFF, 62'h7FFF_FFFF, 62'h3FFF_FFFF_8000_0000,
			62'h2000_0000_0000_0000, 62'h1555_5555_5555_5555, 62'h1FFF_FFFF_FFFF_FFFF
		};
		order_t plan [7] = '{5'd31, 5'd0, 5'd8, 5'd9, 5'd30, 5'd10, 5'd31};
		order_t next_order;

		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset order, largest order, orders below the floor
		foreach (nine_cases[i])
			offer_set(nine_cases[i]);
		write_ring_order(order_t'(MAX_ORDER));
		foreach (top_cases[i])
			offer_set(top_cases[i]);
		write_ring_order(5'd0);
		offer_set(62'h1FF);
		offer_set(62'h3FFF_FFFF_FFFF_FFFF);
		write_ring_order(5'd8);
		offer_set(62'h3FFFF);

		// random phases, one order per phase
		for (int p = 0; p < 10; p++) begin
			next_order = (p < 7) ? plan[p] : order_t'($urandom_range(31));
			write_ring_order(next_order);
			steady = (p == 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// sender holds off until the core has drained
				if (p == 5 && k == 60)
					wait_all_closed();
				offer_set(pick_start_set(sb.order_in_use()));
			end
			steady = 1'b0;
		end

		wait_all_closed();
		repeat (80) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/zfc_pkg.sv
rtl/zfc_ctrl.sv
rtl/zfc_datapath.sv
rtl/zero_forcing_closure_core.sv
sim/testbench.sv
